// File: rtl/wlrl_pkg.sv
package wlrl_pkg;

    localparam int WORD_W          = 32;
    localparam int NUM_PARAMS_DEF  = 4;
    localparam int NUM_SLOTS_DEF   = 16;
    localparam logic [WORD_W-1:0] ERASED_WORD = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        CMD_SCAN  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_ERASE = 2'd3
    } t_command;

    typedef struct packed {
        t_command           command;
        logic [1:0]         param_index;
        logic [WORD_W-1:0]  word_value;
        logic               commit_last;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0]  read_word;
        logic [WORD_W-1:0]  newest_sequence;
        logic [3:0]         newest_slot;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic accept_single;  // non-scan command taken this cycle
        logic start_scan;     // scan taken this cycle
        logic scan_read;      // read next slot row
        logic scan_tail;      // last compare, load result
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_free;       // result register can take a new result
        logic rd_last;        // read address is at the last slot
    } t_dp_sts;

endpackage

// File: rtl/wlrl_stream_if.sv
interface wlrl_stream_if #(
    parameter type T_PAYLOAD = logic
) ();
    logic     valid;
    logic     ready;
    T_PAYLOAD payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/wlrl_ctrl.sv
module wlrl_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  wlrl_pkg::t_command  i_command,
    input  wlrl_pkg::t_dp_sts   i_sts,
    output logic                o_in_ready,
    output wlrl_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_TAIL = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign o_in_ready = (r_state == ST_IDLE) && i_sts.out_free;
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_command == wlrl_pkg::CMD_SCAN) begin
                        o_cmd.start_scan = 1'b1;
                        n_state          = ST_READ;
                    end else begin
                        o_cmd.accept_single = 1'b1;
                    end
                end
            end
            ST_READ: begin
                o_cmd.scan_read = 1'b1;
                if (i_sts.rd_last) begin
                    n_state = ST_TAIL;
                end
            end
            ST_TAIL: begin
                o_cmd.scan_tail = 1'b1;
                n_state         = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: rtl/wlrl_datapath.sv
module wlrl_datapath #(
    parameter int NUM_PARAMS = wlrl_pkg::NUM_PARAMS_DEF,
    parameter int NUM_SLOTS  = wlrl_pkg::NUM_SLOTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wlrl_pkg::t_in_item  i_item,
    input  wlrl_pkg::t_dp_cmd   i_cmd,
    output wlrl_pkg::t_dp_sts   o_sts,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output wlrl_pkg::t_out_item o_out_item
);

    localparam int W  = wlrl_pkg::WORD_W;
    localparam int AW = $clog2(NUM_SLOTS);
    localparam int RW = W * (NUM_PARAMS + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(NUM_SLOTS - 1);

    // slot row: sequence in the low word, parameter p in word p+1
    logic [RW-1:0]     r_mem [NUM_SLOTS];
    logic [RW-1:0]     r_rd_row;
    logic [NUM_SLOTS-1:0] r_slot_vld, n_slot_vld;
    logic [AW-1:0]     r_rd_addr, r_rd_slot;
    logic              r_rd_ok;
    logic              r_cmp_live;

    logic [AW-1:0]     r_head_slot, n_head_slot;
    logic [W-1:0]      r_head_seq, n_head_seq;
    logic [W-1:0]      r_cache [NUM_PARAMS];
    logic [W-1:0]      n_cache [NUM_PARAMS];
    logic [W-1:0]      r_stage [NUM_PARAMS];
    logic [W-1:0]      n_stage [NUM_PARAMS];

    logic              r_out_vld;
    wlrl_pkg::t_out_item r_out;

    logic              w_wr_en;
    logic [RW-1:0]     w_wr_row;
    logic [W-1:0]      w_read_word;
    logic [W-1:0]      w_rd_seq;
    logic              w_load;
    logic [AW+3:0]     w_slot_ext;

    assign w_rd_seq = r_rd_row[W-1:0];

    always_comb begin
        n_slot_vld  = r_slot_vld;
        n_head_slot = r_head_slot;
        n_head_seq  = r_head_seq;
        n_cache     = r_cache;
        n_stage     = r_stage;
        w_wr_en     = 1'b0;
        w_read_word = '0;

        if (i_cmd.accept_single) begin
            case (i_item.command)
                wlrl_pkg::CMD_WRITE: begin
                    for (int p = 0; p < NUM_PARAMS; p++) begin
                        if (int'(i_item.param_index) == p) begin
                            n_stage[p] = i_item.word_value;
                        end
                    end
                    if (i_item.commit_last) begin
                        n_head_slot = (r_head_slot == LAST_SLOT) ? '0
                                                                 : r_head_slot + AW'(1);
                        n_head_seq  = r_head_seq + W'(1);
                        n_cache     = n_stage;
                        w_wr_en     = 1'b1;
                        n_slot_vld[n_head_slot] = 1'b1;
                    end
                end
                wlrl_pkg::CMD_READ: begin
                    for (int p = 0; p < NUM_PARAMS; p++) begin
                        if (int'(i_item.param_index) == p) begin
                            w_read_word = r_cache[p];
                        end
                    end
                end
                wlrl_pkg::CMD_ERASE: begin
                    n_slot_vld = '0;
                end
                default: begin
                end
            endcase
        end

        if (i_cmd.start_scan) begin
            n_head_slot = '0;
            n_head_seq  = '0;
            for (int p = 0; p < NUM_PARAMS; p++) begin
                n_cache[p] = '0;
            end
        end

        // adopt the slot read last cycle; ties go to the later slot
        if (r_cmp_live && r_rd_ok && (w_rd_seq != wlrl_pkg::ERASED_WORD)
                && (w_rd_seq >= r_head_seq)) begin
            n_head_slot = r_rd_slot;
            n_head_seq  = w_rd_seq;
            for (int p = 0; p < NUM_PARAMS; p++) begin
                n_cache[p] = r_rd_row[W*(p+1) +: W];
            end
        end
    end

    always_comb begin
        w_wr_row[W-1:0] = n_head_seq;
        for (int p = 0; p < NUM_PARAMS; p++) begin
            w_wr_row[W*(p+1) +: W] = n_stage[p];
        end
    end

    assign w_load     = i_cmd.accept_single || i_cmd.scan_tail;
    assign w_slot_ext = {4'b0000, n_head_slot};

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[n_head_slot] <= w_wr_row;
        end
        if (i_cmd.scan_read) begin
            r_rd_row  <= r_mem[r_rd_addr];
            r_rd_slot <= r_rd_addr;
            r_rd_ok   <= r_slot_vld[r_rd_addr];
        end
        if (i_cmd.start_scan) begin
            r_rd_addr <= '0;
        end else if (i_cmd.scan_read) begin
            r_rd_addr <= r_rd_addr + AW'(1);
        end
        r_stage <= n_stage;
        if (w_load) begin
            r_out.read_word       <= w_read_word;
            r_out.newest_sequence <= n_head_seq;
            r_out.newest_slot     <= w_slot_ext[3:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_vld  <= '0;
            r_head_slot <= '0;
            r_head_seq  <= '0;
            r_cmp_live  <= 1'b0;
            r_out_vld   <= 1'b0;
            for (int p = 0; p < NUM_PARAMS; p++) begin
                r_cache[p] <= '0;
            end
        end else begin
            r_slot_vld  <= n_slot_vld;
            r_head_slot <= n_head_slot;
            r_head_seq  <= n_head_seq;
            r_cmp_live  <= i_cmd.scan_read;
            r_cache     <= n_cache;
            if (w_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_sts.out_free = !r_out_vld || i_out_ready;
    assign o_sts.rd_last  = (r_rd_addr == LAST_SLOT);
    assign o_out_valid    = r_out_vld;
    assign o_out_item     = r_out;

endmodule

// File: rtl/wear_leveling_ring_log.sv
// Wear-leveling ring log: parameter store kept as a ring of NUM_SLOTS slots, each holding
// a 32-bit sequence number and NUM_PARAMS words. Every command transfer yields exactly one
// result transfer carrying the read word (zero unless a read), the newest sequence and the
// newest slot after the command. The result goes into an output register, so the next
// command is taken while that result is transferred. A scan follows its transfer with a
// walk over the slot rows in order through the single read port of the slot memory and a
// final compare. Erase clears all per-slot valid flags together; after reset all slots read
// as erased with no clearing pass.
module wear_leveling_ring_log #(
    parameter int NUM_PARAMS = wlrl_pkg::NUM_PARAMS_DEF,
    parameter int NUM_SLOTS  = wlrl_pkg::NUM_SLOTS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    wlrl_stream_if.sink   i_cmd,
    wlrl_stream_if.source o_rsp
);

    wlrl_pkg::t_dp_cmd   w_cmd;
    wlrl_pkg::t_dp_sts   w_sts;
    wlrl_pkg::t_in_item  w_item;
    wlrl_pkg::t_out_item w_out_item;
    logic                w_in_ready;
    logic                w_out_valid;

    assign w_item = i_cmd.payload;

    // Sequence the scan walk and gate command transfers on an idle controller and a free result register.
    wlrl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .i_command  (w_item.command),
        .i_sts      (w_sts),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    // Hold slot memory, head pointer, cache, staging words and the result register.
    wlrl_datapath #(
        .NUM_PARAMS (NUM_PARAMS),
        .NUM_SLOTS  (NUM_SLOTS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (w_item),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (w_out_valid),
        .o_out_item  (w_out_item)
    );

    assign i_cmd.ready   = w_in_ready;
    assign o_rsp.valid   = w_out_valid;
    assign o_rsp.payload = w_out_item;

`ifndef NO_ASSERTIONS
    // A scan transfer must not produce a result on the next cycle.
    a_scan_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready && (w_item.command == wlrl_pkg::CMD_SCAN))
        |=> !o_rsp.valid)
        else $error("scan produced an early result");

    // Non-scan commands present their result right after the transfer.
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready && (w_item.command != wlrl_pkg::CMD_SCAN))
        |=> o_rsp.valid)
        else $error("missing result after one-cycle command");

    // Erase returns a zero read word.
    a_erase_zero_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready && (w_item.command == wlrl_pkg::CMD_ERASE))
        |=> (o_rsp.payload.read_word == '0))
        else $error("erase result carries nonzero read word");
`endif

endmodule

// File: tb/tb_wear_leveling_ring_log.sv
module tb_wear_leveling_ring_log;
    import wlrl_pkg::*;

    localparam int PARAMS     = NUM_PARAMS_DEF;
    localparam int SLOTS      = NUM_SLOTS_DEF;
    localparam int RUN_LIMIT  = 4_000_000;
    // a scan holds the block for a full slot walk plus the final compare
    localparam int SETTLE_CYC = SLOTS + 8;

    logic i_clk;
    logic i_rst_n;

    wlrl_stream_if #(.T_PAYLOAD(t_in_item))  cmd_if ();
    wlrl_stream_if #(.T_PAYLOAD(t_out_item)) rsp_if ();

    wear_leveling_ring_log u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_rsp   (rsp_if)
    );

    // Shadow of the non-volatile ring, the parameter cache and the staging buffer.
    logic [WORD_W-1:0] ring_seq   [SLOTS];
    logic [WORD_W-1:0] ring_words [SLOTS][PARAMS];
    logic [WORD_W-1:0] cached     [PARAMS];
    logic [WORD_W-1:0] staged     [PARAMS];
    logic [3:0]        head_slot_m;
    logic [WORD_W-1:0] head_seq_m;

    t_in_item  cmd_pending [$];
    t_out_item rsp_expected [$];

    int offered_cnt;
    int taken_cnt;
    int fail_cnt;
    int src_idle_pct;
    int snk_stall_pct;

    // Generator-side record of which staged words have been written; a commit
    // is only issued once every word of the block holds a defined value.
    logic [PARAMS-1:0] staged_mask;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // Apply one command to the shadow state and return the result it yields.
    function automatic t_out_item ring_log_result(input t_in_item it);
        t_out_item r;
        r.read_word = '0;
        case (it.command)
            CMD_SCAN: begin
                head_slot_m = '0;
                head_seq_m  = '0;
                for (int p = 0; p < PARAMS; p++) cached[p] = '0;
                // ties go to the later slot because of the >= compare
                for (int s = 0; s < SLOTS; s++) begin
                    if (ring_seq[s] >= head_seq_m && ring_seq[s] != ERASED_WORD) begin
                        head_slot_m = s[3:0];
                        head_seq_m  = ring_seq[s];
                        for (int p = 0; p < PARAMS; p++) cached[p] = ring_words[s][p];
                    end
                end
            end
            CMD_WRITE: begin
                if (int'(it.param_index) < PARAMS) staged[it.param_index] = it.word_value;
                if (it.commit_last) begin
                    // advance the head with ring wrap, bump the sequence with 32-bit wrap
                    head_slot_m = (int'(head_slot_m) + 1 >= SLOTS) ? 4'd0 : head_slot_m + 4'd1;
                    head_seq_m  = head_seq_m + 1;
                    ring_seq[head_slot_m] = head_seq_m;
                    for (int p = 0; p < PARAMS; p++) begin
                        ring_words[head_slot_m][p] = staged[p];
                        cached[p] = staged[p];
                    end
                end
            end
            CMD_READ: begin
                if (int'(it.param_index) < PARAMS) r.read_word = cached[it.param_index];
            end
            default: begin
                // erase touches the ring only; head and cache survive
                for (int s = 0; s < SLOTS; s++) begin
                    ring_seq[s] = ERASED_WORD;
                    for (int p = 0; p < PARAMS; p++) ring_words[s][p] = ERASED_WORD;
                end
            end
        endcase
        r.newest_sequence = head_seq_m;
        r.newest_slot     = head_slot_m;
        return r;
    endfunction

    // Command driver: present the next pending command, hold it until the transfer.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else if (!(cmd_if.valid && taken_cnt != offered_cnt)) begin
            if (cmd_pending.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                cmd_if.payload <= cmd_pending.pop_front();
                cmd_if.valid   <= 1'b1;
                offered_cnt++;
            end else begin
                cmd_if.valid <= 1'b0;
            end
        end
    end

    // Result sink: stall at random.
    always @(negedge i_clk) begin
        rsp_if.ready <= i_rst_n && ($urandom_range(99) >= snk_stall_pct);
    end

    // Monitor: check the result transfer first, then record the command transfer, so an
    // expectation pushed at this edge can never be matched by a result at the same edge.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (rsp_expected.size() == 0) begin
                    $error("unexpected result: read_word %h newest_sequence %h newest_slot %0d",
                           rsp_if.payload.read_word, rsp_if.payload.newest_sequence,
                           rsp_if.payload.newest_slot);
                    fail_cnt++;
                end else begin
                    want = rsp_expected.pop_front();
                    if (rsp_if.payload.read_word !== want.read_word) begin
                        $error("read_word: expected %h, got %h",
                               want.read_word, rsp_if.payload.read_word);
                        fail_cnt++;
                    end
                    if (rsp_if.payload.newest_sequence !== want.newest_sequence) begin
                        $error("newest_sequence: expected %h, got %h",
                               want.newest_sequence, rsp_if.payload.newest_sequence);
                        fail_cnt++;
                    end
                    if (rsp_if.payload.newest_slot !== want.newest_slot) begin
                        $error("newest_slot: expected %0d, got %0d",
                               want.newest_slot, rsp_if.payload.newest_slot);
                        fail_cnt++;
                    end
                end
            end
            if (cmd_if.valid && cmd_if.ready) begin
                rsp_expected.push_back(ring_log_result(cmd_if.payload));
                taken_cnt++;
            end
        end
    end

    task automatic queue_cmd(input t_command c, input logic [1:0] idx,
                             input logic [WORD_W-1:0] val, input logic last);
        t_in_item it;
        it.command     = c;
        it.param_index = idx;
        it.word_value  = val;
        it.commit_last = last;
        if (c == CMD_WRITE && int'(idx) < PARAMS) staged_mask[idx] = 1'b1;
        cmd_pending.push_back(it);
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(9))
            0:       return '0;
            1:       return ERASED_WORD;
            default: return $urandom;
        endcase
    endfunction

    // Random traffic: mostly complete staged blocks and reads with random content,
    // with loose single writes, scans over aged rings and the odd erase mixed in.
    task automatic queue_random(input int count);
        int n;
        int pick;
        int burst;
        logic [1:0] idx;
        logic last;
        logic [PARAMS-1:0] order_mask;
        n = 0;
        while (n < count) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                // full block in a random index order, committed by the final word
                order_mask = '0;
                for (int k = 0; k < PARAMS; k++) begin
                    do idx = 2'($urandom_range(PARAMS - 1)); while (order_mask[idx]);
                    order_mask[idx] = 1'b1;
                    queue_cmd(CMD_WRITE, idx, pick_word(), (k == PARAMS - 1));
                    n++;
                end
            end else if (pick < 70) begin
                burst = $urandom_range(1, 4);
                for (int k = 0; k < burst; k++) begin
                    queue_cmd(CMD_READ, 2'($urandom_range(3)), $urandom,
                              1'($urandom_range(1)));
                    n++;
                end
            end else if (pick < 88) begin
                // loose write; commit only once the whole block is defined
                idx  = 2'($urandom_range(3));
                last = ($urandom_range(99) < 35) &&
                       ((staged_mask | (PARAMS'(1) << idx)) == {PARAMS{1'b1}});
                queue_cmd(CMD_WRITE, idx, pick_word(), last);
                n++;
            end else if (pick < 97) begin
                queue_cmd(CMD_SCAN, 2'($urandom_range(3)), $urandom, 1'($urandom_range(1)));
                n++;
            end else begin
                queue_cmd(CMD_ERASE, 2'($urandom_range(3)), $urandom, 1'($urandom_range(1)));
                n++;
            end
        end
    endtask

    // Wait until every queued command has transferred and every result has come back.
    task automatic drain();
        while (cmd_pending.size() != 0 || taken_cnt != offered_cnt
               || rsp_expected.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        cmd_if.valid   = 1'b0;
        cmd_if.payload = '0;
        rsp_if.ready   = 1'b0;
        offered_cnt    = 0;
        taken_cnt      = 0;
        fail_cnt       = 0;
        src_idle_pct   = 0;
        snk_stall_pct  = 0;
        staged_mask    = '0;
        head_slot_m    = '0;
        head_seq_m     = '0;
        for (int s = 0; s < SLOTS; s++) begin
            ring_seq[s] = ERASED_WORD;
            for (int p = 0; p < PARAMS; p++) ring_words[s][p] = ERASED_WORD;
        end
        for (int p = 0; p < PARAMS; p++) begin
            cached[p] = '0;
            staged[p] = '0;
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reads and scan on a fresh store, commit flag on non-write commands,
        // extreme words, erase keeping head and cache, scan of an erased ring, and a
        // commit that reuses earlier staged words.
        queue_cmd(CMD_READ,  2'd0, ERASED_WORD,    1'b1);
        queue_cmd(CMD_READ,  2'd3, '0,             1'b0);
        queue_cmd(CMD_SCAN,  2'd0, '0,             1'b1);
        queue_cmd(CMD_WRITE, 2'd0, '0,             1'b0);
        queue_cmd(CMD_WRITE, 2'd1, ERASED_WORD,    1'b0);
        queue_cmd(CMD_WRITE, 2'd2, 32'hA5A5_A5A5,  1'b0);
        queue_cmd(CMD_WRITE, 2'd3, 32'h5A5A_5A5A,  1'b1);
        for (int p = 0; p < 4; p++) queue_cmd(CMD_READ, p[1:0], '0, 1'b0);
        queue_cmd(CMD_ERASE, 2'd1, ERASED_WORD,    1'b1);
        queue_cmd(CMD_READ,  2'd1, '0,             1'b0);
        queue_cmd(CMD_SCAN,  2'd2, ERASED_WORD,    1'b0);
        queue_cmd(CMD_READ,  2'd1, '0,             1'b0);
        queue_cmd(CMD_WRITE, 2'd2, ERASED_WORD,    1'b1);
        queue_cmd(CMD_WRITE, 2'd0, 32'h0000_0001,  1'b1);
        queue_cmd(CMD_SCAN,  2'd3, '0,             1'b0);
        queue_cmd(CMD_READ,  2'd2, '0,             1'b0);
        queue_cmd(CMD_READ,  2'd0, ERASED_WORD,    1'b1);
        drain();

        // Random phases; the sender holds off between them until everything is back.
        src_idle_pct = 0;  snk_stall_pct = 0;
        queue_random(410);
        drain();
        src_idle_pct = 65; snk_stall_pct = 0;
        queue_random(410);
        drain();
        src_idle_pct = 0;  snk_stall_pct = 65;
        queue_random(410);
        drain();
        src_idle_pct = 11; snk_stall_pct = 11;
        queue_random(410);
        drain();

        repeat (SETTLE_CYC) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: wear_leveling_ring_log.f
rtl/wlrl_pkg.sv
rtl/wlrl_stream_if.sv
rtl/wlrl_ctrl.sv
rtl/wlrl_datapath.sv
rtl/wear_leveling_ring_log.sv
tb/tb_wear_leveling_ring_log.sv
